@@ src/fcct_pkg.sv @@
// Shared types and constants for the cluster chain table.
// Holds field widths, command codes, datapath micro-operations and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package fcct_pkg;

  // Widths of the transaction fields.
  localparam int CMD_W     = 3;
  localparam int CLUSTER_W = 6;
  localparam int BYTES_W   = 16;
  localparam int NEXT_W    = 7;
  localparam int VALUE_W   = 7;

  // Default geometry of the table.
  localparam int TABLE_ENTRIES_DEF       = 64;
  localparam int SECTORS_PER_CLUSTER_DEF = 1;
  localparam int SECTOR_BYTES_DEF        = 128;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LINK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,        // capture the transaction and start the divider
    DP_CLEAR,       // write the reset value of the entry at the index, step up
    DP_READ,        // read the entry at the index
    DP_READ_LAST,   // point the index at the last entry and read it
    DP_ADD_LINK,    // link the entry to its successor, read the successor
    DP_WRITE_EOF,   // mark the entry at the index as end of chain
    DP_FREE,        // free the entry at the index
    DP_FREE_FOLLOW, // free the entry and follow its link
    DP_FIND_DOWN,   // step the index down and read
    DP_LINK_WRITE   // store the link value at the index
  } dp_op_e;

  // Result source selected when a transaction finishes.
  typedef enum logic [2:0] {
    RES_FAIL,
    RES_OK,
    RES_READ,
    RES_FOUND,
    RES_NONE
  } res_e;

  typedef struct packed {
    dp_op_e op;
    logic   finish;
    res_e   res;
  } dp_cmd_t;

  typedef struct packed {
    logic in_table;  // cluster lies inside the table
    logic div_done;  // allocation size is ready
    logic n_zero;    // allocation size is zero clusters
    logic fits;      // start plus size lies inside the table
    logic v_free;    // read entry is free
    logic v_eof;     // read entry marks end of chain
    logic v_link;    // read entry is a link into the table
    logic v_self;    // read link points back at its own entry
    logic at_end;    // next index is the end of the run being added
    logic at_last;   // index is the last entry
    logic at_first;  // index is entry one
  } dp_status_t;

endpackage

@@ src/fcct_div.sv @@
// Division of the byte count by a constant cluster size, by multiplying with
// a rounded-up reciprocal. Depends on fcct_pkg for the byte count width.
`timescale 1ns / 1ps

module fcct_div
  import fcct_pkg::*;
#(
  parameter int DIVISOR = SECTORS_PER_CLUSTER_DEF * SECTOR_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [BYTES_W-1:0] dividend_i,
  output logic               done_o,
  output logic [BYTES_W-1:0] quot_o
);

  // With the reciprocal rounded up over BYTES_W plus log2 of the divisor
  // bits, the truncated product is the exact quotient for every dividend.
  localparam int ShiftW = BYTES_W + $clog2(DIVISOR);
  localparam int RecipW = BYTES_W + 2;
  localparam int ProdW  = BYTES_W + RecipW;
  localparam longint unsigned RecipL =
    ((64'd1 << ShiftW) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  logic [ProdW-1:0]   prod;
  logic [BYTES_W-1:0] quo_q, quo_d;
  logic               done_q;

  // Quotient of the incoming byte count.
  assign prod  = ProdW'(dividend_i) * ProdW'(Recip);
  assign quo_d = BYTES_W'(prod >> ShiftW);

  // The quotient is ready in the cycle after the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ src/fcct_dpath.sv @@
// Datapath of the cluster chain table: table memory, index register,
// size divider and result registers. Depends on fcct_pkg and fcct_div.
`timescale 1ns / 1ps

module fcct_dpath
  import fcct_pkg::*;
#(
  parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
  parameter int SECTORS_PER_CLUSTER = SECTORS_PER_CLUSTER_DEF,
  parameter int SECTOR_BYTES        = SECTOR_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o,
  input  logic [CLUSTER_W-1:0]        cluster_i,
  input  logic [BYTES_W-1:0]          byte_count_i,
  input  logic signed [NEXT_W-1:0]    next_cluster_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic signed [VALUE_W-1:0]   value_o
);

  localparam int ClusterBytes = SECTORS_PER_CLUSTER * SECTOR_BYTES;
  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  localparam int EntryW = (IdxW + 2 > 8) ? IdxW + 2 : 8;
  localparam int SumW   = BYTES_W + 1;

  localparam logic signed [EntryW-1:0] EntryN        = EntryW'(TABLE_ENTRIES);
  localparam logic signed [EntryW-1:0] EntryEof      = '1;
  localparam logic signed [EntryW-1:0] EntryReserved = -EntryW'(2);
  localparam logic [IdxW-1:0]          IdxLast       = IdxW'(TABLE_ENTRIES - 1);

  // Table memory with a registered read port.
  logic signed [EntryW-1:0] mem [TABLE_ENTRIES];
  logic signed [EntryW-1:0] rdata_q;
  logic                     we;
  logic [IdxW-1:0]          raddr;
  logic signed [EntryW-1:0] wdata;

  logic [IdxW-1:0]              idx_q, idx_d;
  logic [IdxW:0]                idx_inc;
  logic [CLUSTER_W-1:0]         cluster_q;
  logic signed [NEXT_W-1:0]     nxt_q;
  logic                         done_q;
  logic                         ok_q, ok_d;
  logic signed [VALUE_W-1:0]    value_q, value_d;
  logic                         div_done;
  logic [BYTES_W-1:0]           quot;
  logic [SumW-1:0]              run_end;

  fcct_div #(
    .DIVISOR (ClusterBytes)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == DP_LOAD),
    .dividend_i (byte_count_i),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign idx_inc = (IdxW + 1)'(idx_q) + 1'b1;
  assign run_end = SumW'(cluster_q) + SumW'(quot);

  // Memory access and index update for each micro-operation.
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    raddr = idx_q;
    idx_d = idx_q;
    case (cmd_i.op)
      DP_LOAD: begin
        idx_d = IdxW'(cluster_i);
      end
      DP_CLEAR: begin
        we    = 1'b1;
        wdata = (idx_q < IdxW'(2)) ? EntryReserved : '0;
        idx_d = IdxW'(idx_inc);
      end
      DP_READ_LAST: begin
        raddr = IdxLast;
        idx_d = IdxLast;
      end
      DP_ADD_LINK: begin
        we    = 1'b1;
        wdata = $signed(EntryW'(idx_inc));
        raddr = IdxW'(idx_inc);
        idx_d = IdxW'(idx_inc);
      end
      DP_WRITE_EOF: begin
        we    = 1'b1;
        wdata = EntryEof;
      end
      DP_FREE: begin
        we = 1'b1;
      end
      DP_FREE_FOLLOW: begin
        we    = 1'b1;
        raddr = rdata_q[IdxW-1:0];
        idx_d = rdata_q[IdxW-1:0];
      end
      DP_FIND_DOWN: begin
        raddr = idx_q - 1'b1;
        idx_d = idx_q - 1'b1;
      end
      DP_LINK_WRITE: begin
        we    = 1'b1;
        wdata = EntryW'(nxt_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // The index also walks the clearing pass, so it starts from zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      cluster_q <= cluster_i;
      nxt_q     <= next_cluster_i;
    end
  end

  // Result selection when the controller closes a transaction.
  always_comb begin
    case (cmd_i.res)
      RES_OK: begin
        ok_d    = 1'b1;
        value_d = '0;
      end
      RES_READ: begin
        ok_d    = 1'b1;
        value_d = rdata_q[VALUE_W-1:0];
      end
      RES_FOUND: begin
        ok_d    = 1'b1;
        value_d = VALUE_W'(idx_inc);
      end
      RES_NONE: begin
        ok_d    = 1'b0;
        value_d = '1;
      end
      default: begin
        ok_d    = 1'b0;
        value_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      ok_q    <= ok_d;
      value_q <= value_d;
    end
  end

  // Status flags for the controller.
  always_comb begin
    status_o.in_table = 32'(cluster_q) < 32'(TABLE_ENTRIES);
    status_o.div_done = div_done;
    status_o.n_zero   = quot == '0;
    status_o.fits     = run_end < SumW'(TABLE_ENTRIES);
    status_o.v_free   = rdata_q == '0;
    status_o.v_eof    = rdata_q == EntryEof;
    status_o.v_link   = !rdata_q[EntryW-1] && (rdata_q != '0) && (rdata_q < EntryN);
    status_o.v_self   = rdata_q[IdxW-1:0] == idx_q;
    status_o.at_end   = idx_inc == (IdxW + 1)'(run_end);
    status_o.at_last  = idx_q == IdxLast;
    status_o.at_first = idx_q == IdxW'(1);
  end

  assign done_o  = done_q;
  assign ok_o    = ok_q;
  assign value_o = value_q;

endmodule

@@ src/fcct_ctrl.sv @@
// Controller of the cluster chain table: sequences clearing, command
// dispatch and the table walks. Depends on fcct_pkg.
`timescale 1ns / 1ps

module fcct_ctrl
  import fcct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMD_W-1:0] command_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o,
  output logic             busy_o
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DIV       = 4'd2;
  localparam logic [3:0] S_ADD_DEC   = 4'd3;
  localparam logic [3:0] S_ADD_CHK   = 4'd4;
  localparam logic [3:0] S_ADD_END   = 4'd5;
  localparam logic [3:0] S_RM_RD     = 4'd6;
  localparam logic [3:0] S_RM_CHK    = 4'd7;
  localparam logic [3:0] S_FIND_RD   = 4'd8;
  localparam logic [3:0] S_FIND_CHK  = 4'd9;
  localparam logic [3:0] S_LINK_RD   = 4'd10;
  localparam logic [3:0] S_LINK_CHK  = 4'd11;
  localparam logic [3:0] S_GET_RD    = 4'd12;
  localparam logic [3:0] S_GET_CHK   = 4'd13;

  logic [3:0] state_q, state_d;

  // Next state and datapath command.
  always_comb begin
    state_d      = state_q;
    cmd_o.op     = DP_NOP;
    cmd_o.finish = 1'b0;
    cmd_o.res    = RES_FAIL;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (status_i.at_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = DP_LOAD;
          case (command_i)
            CMD_ADD:    state_d = S_DIV;
            CMD_REMOVE: state_d = S_RM_RD;
            CMD_FIND:   state_d = S_FIND_RD;
            CMD_LINK:   state_d = S_LINK_RD;
            CMD_GET:    state_d = S_GET_RD;
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_ADD_DEC;
        end
      end
      S_ADD_DEC: begin
        if (!status_i.in_table) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.n_zero) begin
          cmd_o.op     = DP_WRITE_EOF;
          cmd_o.finish = 1'b1;
          cmd_o.res    = RES_OK;
          state_d      = S_IDLE;
        end else if (!status_i.fits) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_ADD_CHK;
        end
      end
      // Link one free entry per cycle; a used entry aborts the run.
      S_ADD_CHK: begin
        if (!status_i.v_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_ADD_LINK;
          if (status_i.at_end) begin
            state_d = S_ADD_END;
          end
        end
      end
      S_ADD_END: begin
        cmd_o.op     = DP_WRITE_EOF;
        cmd_o.finish = 1'b1;
        cmd_o.res    = RES_OK;
        state_d      = S_IDLE;
      end
      S_RM_RD: begin
        if (!status_i.in_table) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = RES_OK;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_RM_CHK;
        end
      end
      // Free along the chain; a link back to itself ends the walk.
      S_RM_CHK: begin
        if (status_i.v_link && !status_i.v_self) begin
          cmd_o.op = DP_FREE_FOLLOW;
        end else begin
          if (status_i.v_eof || status_i.v_link) begin
            cmd_o.op = DP_FREE;
          end
          cmd_o.finish = 1'b1;
          cmd_o.res    = RES_OK;
          state_d      = S_IDLE;
        end
      end
      S_FIND_RD: begin
        cmd_o.op = DP_READ_LAST;
        state_d  = S_FIND_CHK;
      end
      // Scan down from the last entry for the highest used one.
      S_FIND_CHK: begin
        if (status_i.at_last) begin
          if (!status_i.v_free) begin
            cmd_o.finish = 1'b1;
            cmd_o.res    = RES_NONE;
            state_d      = S_IDLE;
          end else begin
            cmd_o.op = DP_FIND_DOWN;
          end
        end else if (!status_i.v_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = RES_FOUND;
          state_d      = S_IDLE;
        end else if (status_i.at_first) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = RES_NONE;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_FIND_DOWN;
        end
      end
      S_LINK_RD: begin
        if (!status_i.in_table) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_LINK_CHK;
        end
      end
      S_LINK_CHK: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
        if (status_i.v_free || status_i.v_eof) begin
          cmd_o.op  = DP_LINK_WRITE;
          cmd_o.res = RES_OK;
        end
      end
      S_GET_RD: begin
        if (!status_i.in_table) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_GET_CHK;
        end
      end
      S_GET_CHK: begin
        cmd_o.finish = 1'b1;
        cmd_o.res    = RES_READ;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

@@ src/fat_cluster_chain_table.sv @@
// Top level of the cluster chain table: controller plus datapath.
// Depends on fcct_pkg, fcct_ctrl and fcct_dpath.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low, and its single
// result appears on ok_o and value_o for exactly one cycle with done_o high;
// the receiver cannot stall it. After reset the block sweeps the table memory
// once, one entry per cycle, and holds busy high until the sweep is done.
// Each transaction walks the table through its one read and one write port:
// get next and link next read the entry and then check it, remove reads and
// frees one entry after the other along the chain, find reads entries one by
// one down from the last one (at most TABLE_ENTRIES - 1 of them), and add
// waits for the cluster count from a registered reciprocal multiply, checks
// the start and size, and, for a run of one or more clusters, checks and
// links each cluster in turn and then writes the end-of-chain mark. The
// result follows in the cycle after the last step, and busy drops in that
// same cycle.
module fat_cluster_chain_table
  import fcct_pkg::*;
#(
  parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
  parameter int SECTORS_PER_CLUSTER = SECTORS_PER_CLUSTER_DEF,
  parameter int SECTOR_BYTES        = SECTOR_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          command_i,
  input  logic [CLUSTER_W-1:0]      cluster_i,
  input  logic [BYTES_W-1:0]        byte_count_i,
  input  logic signed [NEXT_W-1:0]  next_cluster_i,
  output logic                      done_o,
  output logic                      ok_o,
  output logic signed [VALUE_W-1:0] value_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencing of each transaction.
  fcct_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd),
    .busy_o    (busy)
  );

  // Table storage and result registers.
  fcct_dpath #(
    .TABLE_ENTRIES       (TABLE_ENTRIES),
    .SECTORS_PER_CLUSTER (SECTORS_PER_CLUSTER),
    .SECTOR_BYTES        (SECTOR_BYTES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .cluster_i      (cluster_i),
    .byte_count_i   (byte_count_i),
    .next_cluster_i (next_cluster_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .value_o        (value_o)
  );

endmodule

@@ bench/fat_cluster_chain_table_test.sv @@
// Self-checking testbench for the cluster chain table (fat_cluster_chain_table).
// Drives add, remove, find, link and get transactions and checks every result against a
// mirror of the chain table kept in a scoreboard class. Depends on fcct_pkg and the RTL.
`timescale 1ns / 1ps

module fat_cluster_chain_table_test;
  import fcct_pkg::*;

  localparam int TABLE_N       = TABLE_ENTRIES_DEF;
  localparam int CLUSTER_BYTES = SECTORS_PER_CLUSTER_DEF * SECTOR_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 120;

  // Entry encodings of the chain table.
  localparam int ENTRY_FREE     = 0;
  localparam int ENTRY_EOF      = -1;
  localparam int ENTRY_RESERVED = -2;

  // Command codes that the block does not implement.
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] value;
  } chain_result_t;

  // Mirror of the chain table plus the results still owed by the block.
  class chain_table_scoreboard;
    logic signed [7:0] entry [TABLE_N];
    chain_result_t     awaited [$];
    int unsigned       errors;

    function new();
      foreach (entry[i]) entry[i] = 8'(ENTRY_FREE);
      entry[0] = 8'(ENTRY_RESERVED);
      entry[1] = 8'(ENTRY_RESERVED);
      errors = 0;
    endfunction

    function logic signed [7:0] entry_at(logic [CLUSTER_W-1:0] idx);
      return entry[idx];
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Apply one accepted transaction to the mirror and queue its result.
    function void note_command(logic [CMD_W-1:0] cmd, logic [CLUSTER_W-1:0] cl,
                               logic [BYTES_W-1:0] bytes,
                               logic signed [NEXT_W-1:0] nxt);
      chain_result_t res;
      int n;
      int idx;
      int i;
      int v;
      res.ok    = 1'b0;
      res.value = '0;
      idx       = int'(cl);
      case (cmd)
        CMD_ADD: begin
          n = bytes / CLUSTER_BYTES;
          if (n == 0) begin
            entry[idx] = 8'(ENTRY_EOF);
            res.ok     = 1'b1;
          end else if (idx + n < TABLE_N) begin
            // Links written before a used entry is met are kept.
            res.ok = 1'b1;
            for (i = idx; i < idx + n; i++) begin
              if (entry[i] != ENTRY_FREE) begin
                res.ok = 1'b0;
                break;
              end
              entry[i] = 8'(i + 1);
            end
            if (res.ok) entry[idx + n] = 8'(ENTRY_EOF);
          end
        end
        CMD_REMOVE: begin
          // Follow links, freeing as we go; stop on anything that is not a link.
          for (i = 0; i <= TABLE_N; i++) begin
            v = int'(entry[idx]);
            if (v == ENTRY_EOF) begin
              entry[idx] = 8'(ENTRY_FREE);
              break;
            end
            if (v < 1 || v >= TABLE_N) break;
            entry[idx] = 8'(ENTRY_FREE);
            idx = v;
          end
          res.ok = 1'b1;
        end
        CMD_FIND: begin
          v = -1;
          if (entry[TABLE_N-1] == ENTRY_FREE) begin
            for (i = TABLE_N - 2; i > 0; i--) begin
              if (entry[i] != ENTRY_FREE) begin
                v = i + 1;
                break;
              end
            end
          end
          res.ok    = (v >= 0);
          res.value = VALUE_W'(v);
        end
        CMD_LINK: begin
          if (entry[idx] == ENTRY_FREE || entry[idx] == ENTRY_EOF) begin
            entry[idx] = 8'(nxt);
            res.ok     = 1'b1;
          end
        end
        CMD_GET: begin
          res.value = VALUE_W'(entry[idx]);
          res.ok    = 1'b1;
        end
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(logic ok, logic signed [VALUE_W-1:0] value);
      chain_result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ok=%0b value=%0d", $time, ok, value);
        return;
      end
      exp = awaited.pop_front();
      if (exp.ok !== ok || exp.value !== value) begin
        errors++;
        $display("%0t: result mismatch: expected ok=%0b value=%0d, actual ok=%0b value=%0d",
                 $time, exp.ok, exp.value, ok, value);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [CMD_W-1:0]          command_i = CMD_GET;
  logic [CLUSTER_W-1:0]      cluster_i = '0;
  logic [BYTES_W-1:0]        byte_count_i = '0;
  logic signed [NEXT_W-1:0]  next_cluster_i = '0;
  logic                      done_o;
  logic                      ok_o;
  logic signed [VALUE_W-1:0] value_o;

  chain_table_scoreboard board = new();
  int burst_left = 1;
  int idle_cycles = 0;

  fat_cluster_chain_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .cluster_i      (cluster_i),
    .byte_count_i   (byte_count_i),
    .next_cluster_i (next_cluster_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .value_o        (value_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every result strobe against the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(ok_o, value_o);
  end

  // End the run if nothing is accepted or finished for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fat_cluster_chain_table: mismatch");
      $finish;
    end
  end

  // Present one transaction, wait for it to be taken, then idle if the burst is over.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [CLUSTER_W-1:0] cl,
                       logic [BYTES_W-1:0] bytes, logic signed [NEXT_W-1:0] nxt);
    int gap;
    command_i      <= cmd;
    cluster_i      <= cl;
    byte_count_i   <= bytes;
    next_cluster_i <= nxt;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_command(cmd, cl, bytes, nxt);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Pick a cluster that is in use, or one that a link may overwrite.
  function automatic logic [CLUSTER_W-1:0] pick_cluster(bit want_used);
    logic [CLUSTER_W-1:0] cl;
    logic signed [7:0]    e;
    int                   tries;
    cl = '0;
    for (tries = 0; tries < 8; tries++) begin
      cl = CLUSTER_W'($urandom_range(0, TABLE_N - 1));
      e  = board.entry_at(cl);
      if (want_used ? (e != ENTRY_FREE) : (e == ENTRY_FREE || e == ENTRY_EOF)) break;
    end
    return cl;
  endfunction

  // One random transaction, weighted toward chains that get built and torn down.
  task automatic random_command();
    int                       r;
    logic [CLUSTER_W-1:0]     cl;
    logic [BYTES_W-1:0]       bytes;
    logic signed [NEXT_W-1:0] nxt;
    r     = $urandom_range(0, 99);
    cl    = CLUSTER_W'($urandom_range(0, TABLE_N - 1));
    bytes = BYTES_W'($urandom());
    nxt   = NEXT_W'($urandom());
    if (r < 30) begin
      if ($urandom_range(0, 9) < 8)
        bytes = BYTES_W'($urandom_range(0, 6) * CLUSTER_BYTES + $urandom_range(0, 127));
      if ($urandom_range(0, 9) < 7) cl = pick_cluster(1'b0);
      issue(CMD_ADD, cl, bytes, nxt);
    end else if (r < 55) begin
      if ($urandom_range(0, 9) < 7) cl = pick_cluster(1'b1);
      issue(CMD_REMOVE, cl, bytes, nxt);
    end else if (r < 65) begin
      issue(CMD_FIND, cl, bytes, nxt);
    end else if (r < 80) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: nxt = NEXT_W'($urandom_range(1, TABLE_N - 1));
        5, 6:          nxt = NEXT_W'(ENTRY_EOF);
        default:       ;
      endcase
      if ($urandom_range(0, 9) < 7) cl = pick_cluster(1'b0);
      issue(CMD_LINK, cl, bytes, nxt);
    end else if (r < 96) begin
      issue(CMD_GET, cl, bytes, nxt);
    end else begin
      issue(CMD_W'(CMD_LINK + $urandom_range(CMD_UNUSED_FIRST - CMD_LINK,
                                             CMD_UNUSED_LAST - CMD_LINK)), cl, bytes, nxt);
    end
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset contents, unused commands, run fit limits, partial adds,
    // cyclic and non-link chains, and find with and without a free slot.
    issue(CMD_GET, 6'd0, 16'h0000, 7'sd0);
    issue(CMD_FIND, 6'd0, 16'h0000, 7'sd0);
    issue(CMD_UNUSED_FIRST, 6'd63, 16'hFFFF, NEXT_W'(ENTRY_EOF));
    issue(CMD_UNUSED_LAST, 6'd0, 16'h0000, 7'sd0);
    issue(CMD_ADD, 6'd1, 16'd0, 7'sd0);
    issue(CMD_REMOVE, 6'd1, 16'd0, 7'sd0);
    issue(CMD_FIND, 6'd0, 16'd0, 7'sd0);
    issue(CMD_ADD, 6'd60, 16'd384, 7'sd0);
    issue(CMD_FIND, 6'd0, 16'd0, 7'sd0);
    issue(CMD_ADD, 6'd61, 16'd384, 7'sd0);
    issue(CMD_ADD, 6'd10, 16'hFFFF, 7'sd0);
    issue(CMD_REMOVE, 6'd60, 16'd0, 7'sd0);
    issue(CMD_LINK, 6'd23, 16'd0, NEXT_W'(ENTRY_EOF));
    issue(CMD_ADD, 6'd20, 16'd767, 7'sd0);
    issue(CMD_GET, 6'd21, 16'd0, 7'sd0);
    issue(CMD_REMOVE, 6'd20, 16'd0, 7'sd0);
    issue(CMD_LINK, 6'd40, 16'd0, 7'sd41);
    issue(CMD_LINK, 6'd41, 16'd0, 7'sd40);
    issue(CMD_REMOVE, 6'd40, 16'd0, 7'sd0);
    issue(CMD_LINK, 6'd30, 16'd0, NEXT_W'(-64));
    issue(CMD_LINK, 6'd30, 16'd0, 7'sd63);
    issue(CMD_REMOVE, 6'd30, 16'd0, 7'sd0);
    issue(CMD_GET, 6'd63, 16'd0, 7'sd0);
    issue(CMD_ADD, 6'd2, 16'd127, 7'sd0);
    issue(CMD_ADD, 6'd2, 16'd128, 7'sd0);

    for (k = 0; k < RANDOM_ITEMS; k++) random_command();

    // Drain the remaining results, then give late strobes time to show up.
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("fat_cluster_chain_table: match");
    end else begin
      $display("fat_cluster_chain_table: mismatch");
    end
    $finish;
  end

endmodule
